// ===== hdl/lmbpw_pkg.sv =====
// Shared types, constants and gamma tables for the bit-plane pixel writer.
package lmbpw_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int HALF_ROWS_DEF    = 32;
    localparam int PLANE_COUNT_DEF  = 16;

    localparam int STORE_DEPTH = 65536;
    localparam int STORE_AW    = 16;
    localparam int PIX_AW      = 20;
    localparam int CHAN_W      = 16;
    localparam int BYTE_W      = 6;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_FILL    = 3'd1,
        CMD_WINDOW  = 3'd2,
        CMD_PIX565  = 3'd3,
        CMD_PIX565T = 3'd4,
        CMD_PIX444  = 3'd5,
        CMD_READ    = 3'd6
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_PIX,
        S_START,
        S_PLANE,
        S_NEXT,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic latch;
        logic clr_start;
        logic clr_step;
        logic fill_start;
        logic win_set;
        logic strm_start;
        logic set_skip;
        logic pix_base;
        logic plane_start;
        logic px_next;
        logic cur_advance;
        logic rd_capture;
        logic out_load;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic rect_empty;
        logic exhausted;
        logic transparent;
        logic on_panel;
        logic plane_done;
        logic clr_done;
        logic px_last_col;
        logic px_last_row;
        logic out_blocked;
    } t_dp_stat;

    localparam logic [15:0] GAMMA5 [32] = '{
        16'd0,     16'd68,    16'd273,   16'd614,   16'd1091,  16'd1705,  16'd2455,  16'd3342,
        16'd4364,  16'd5524,  16'd6819,  16'd8252,  16'd9820,  16'd11525, 16'd13366, 16'd15344,
        16'd17458, 16'd19708, 16'd22095, 16'd24618, 16'd27278, 16'd30074, 16'd33006, 16'd36075,
        16'd39280, 16'd42622, 16'd46100, 16'd49714, 16'd53465, 16'd57352, 16'd61375, 16'd65535
    };

    localparam logic [15:0] GAMMA6 [64] = '{
        16'd0,     16'd17,    16'd66,    16'd149,   16'd264,   16'd413,   16'd594,   16'd809,
        16'd1057,  16'd1337,  16'd1651,  16'd1998,  16'd2378,  16'd2790,  16'd3236,  16'd3715,
        16'd4227,  16'd4772,  16'd5350,  16'd5961,  16'd6605,  16'd7282,  16'd7992,  16'd8735,
        16'd9511,  16'd10320, 16'd11162, 16'd12037, 16'd12945, 16'd13886, 16'd14861, 16'd15868,
        16'd16908, 16'd17981, 16'd19088, 16'd20227, 16'd21399, 16'd22605, 16'd23843, 16'd25114,
        16'd26419, 16'd27756, 16'd29127, 16'd30530, 16'd31967, 16'd33436, 16'd34939, 16'd36474,
        16'd38043, 16'd39645, 16'd41279, 16'd42947, 16'd44648, 16'd46381, 16'd48148, 16'd49948,
        16'd51781, 16'd53647, 16'd55545, 16'd57477, 16'd59442, 16'd61440, 16'd63471, 16'd65535
    };

    function automatic logic [CHAN_W-1:0] gamma5(input logic [4:0] idx);
        return GAMMA5[idx];
    endfunction

    function automatic logic [CHAN_W-1:0] gamma6(input logic [5:0] idx);
        return GAMMA6[idx];
    endfunction

endpackage

// ===== hdl/lmbpw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module lmbpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lmbpw_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module lmbpw_ctrl
    import lmbpw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   is_fill;
    logic   is_stream;

    assign is_fill   = (i_stat.cmd == CMD_FILL);
    assign is_stream = (i_stat.cmd == CMD_PIX565) || (i_stat.cmd == CMD_PIX565T) ||
                       (i_stat.cmd == CMD_PIX444);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd) inside
                    CMD_CLEAR:  n_state = S_CLEAR;
                    CMD_FILL:   n_state = i_stat.rect_empty ? S_FINISH : S_PIX;
                    CMD_WINDOW: n_state = S_FINISH;
                    CMD_PIX565, CMD_PIX565T, CMD_PIX444: begin
                        if (i_stat.exhausted) begin
                            n_state = S_FINISH;
                        end else if (i_stat.transparent) begin
                            n_state = S_NEXT;
                        end else begin
                            n_state = S_PIX;
                        end
                    end
                    CMD_READ:   n_state = S_READ;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_FINISH;
                end
            end
            S_PIX:   n_state = i_stat.on_panel ? S_START : S_NEXT;
            S_START: n_state = S_PLANE;
            S_PLANE: begin
                if (i_stat.plane_done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (is_fill && !(i_stat.px_last_col && i_stat.px_last_row)) begin
                    n_state = S_PIX;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_READ:  n_state = S_FINISH;
            S_FINISH: begin
                if (!i_stat.out_blocked) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_ctl.latch = i_valid;
            end
            S_DECODE: begin
                unique case (i_stat.cmd) inside
                    CMD_CLEAR:  o_ctl.clr_start = 1'b1;
                    CMD_FILL:   o_ctl.fill_start = 1'b1;
                    CMD_WINDOW: o_ctl.win_set = 1'b1;
                    CMD_PIX565, CMD_PIX565T, CMD_PIX444: begin
                        o_ctl.strm_start = 1'b1;
                        o_ctl.set_skip   = i_stat.exhausted || i_stat.transparent;
                    end
                    default: ;
                endcase
            end
            S_CLEAR:  o_ctl.clr_step = 1'b1;
            S_PIX: begin
                o_ctl.pix_base = 1'b1;
                o_ctl.set_skip = is_stream && !i_stat.on_panel;
            end
            S_START:  o_ctl.plane_start = 1'b1;
            S_PLANE:  ;
            S_NEXT: begin
                o_ctl.px_next     = is_fill;
                o_ctl.cur_advance = is_stream;
            end
            S_READ:   o_ctl.rd_capture = 1'b1;
            S_FINISH: o_ctl.out_load = !i_stat.out_blocked;
            default: ;
        endcase
    end

endmodule

// ===== hdl/lmbpw_dp.sv =====
// Datapath: request registers, window cursor, plane read-modify-write and frame store.
module lmbpw_dp
    import lmbpw_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int HALF_ROWS    = HALF_ROWS_DEF,
    parameter int PLANE_COUNT  = PLANE_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_ctl       i_ctl,
    output t_dp_stat      o_stat,
    input  logic [2:0]    i_command,
    input  logic [7:0]    i_left_col,
    input  logic [6:0]    i_top_row,
    input  logic [7:0]    i_right_col,
    input  logic [6:0]    i_bottom_row,
    input  logic [15:0]   i_colour,
    input  logic [15:0]   i_read_address,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [5:0]    o_read_data,
    output logic          o_skipped,
    output logic          o_window_done
);

    localparam int PC_W        = $clog2(PLANE_COUNT + 1);
    localparam int LINE_STRIDE = PANEL_WIDTH * PLANE_COUNT;

    // Request registers.
    t_cmd                r_cmd;
    logic [7:0]          r_left;
    logic [6:0]          r_top;
    logic [7:0]          r_right;
    logic [6:0]          r_bottom;
    logic [15:0]         r_colour;
    logic [STORE_AW-1:0] r_raddr_req;

    // Window and cursor.
    logic [7:0] r_win_left;
    logic [7:0] r_win_right;
    logic [6:0] r_win_top;
    logic [6:0] r_win_bottom;
    logic [7:0] r_cur_col;
    logic [6:0] r_cur_row;
    logic       r_exhausted;

    // Pixel and plane sequencing.
    logic [7:0]        r_px_col;
    logic [6:0]        r_px_row;
    logic              r_upper;
    logic [PIX_AW-1:0] r_base;
    logic [CHAN_W-1:0] r_red_src;
    logic [CHAN_W-1:0] r_grn_src;
    logic [CHAN_W-1:0] r_blu_src;
    logic [CHAN_W-1:0] r_red_sh;
    logic [CHAN_W-1:0] r_grn_sh;
    logic [CHAN_W-1:0] r_blu_sh;
    logic [PC_W-1:0]   r_plane;
    logic              r_plane_act;
    logic              r_wr_pend;
    logic [PIX_AW-1:0] r_wr_addr;
    logic [2:0]        r_wr_rgb;
    logic [STORE_AW-1:0] r_clr_cnt;

    // Result and output registers.
    logic [5:0] r_res_data;
    logic       r_res_skip;
    logic       r_res_done;
    logic       r_out_valid;
    logic [5:0] r_out_data;
    logic       r_out_skip;
    logic       r_out_done;

    logic                n_upper;
    logic [6:0]          n_line;
    logic [PIX_AW-1:0]   n_base;
    logic [PIX_AW-1:0]   n_plane_addr;
    logic                n_issue;
    logic [CHAN_W-1:0]   n_red;
    logic [CHAN_W-1:0]   n_grn;
    logic [CHAN_W-1:0]   n_blu;
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                cur_last_col;
    logic                cur_last_row;

    assign n_upper = (r_px_row >= 7'(HALF_ROWS));
    assign n_line  = n_upper ? 7'(r_px_row - 7'(HALF_ROWS)) : r_px_row;
    assign n_base  = PIX_AW'(n_line) * PIX_AW'(LINE_STRIDE) +
                     PIX_AW'(r_px_col) * PIX_AW'(PLANE_COUNT);

    assign n_plane_addr = r_base + PIX_AW'(r_plane);
    assign n_issue      = r_plane_act && (r_plane < PC_W'(PLANE_COUNT));

    always_comb begin
        if (r_cmd == CMD_PIX444) begin
            n_red = {r_colour[11:8], 12'h000};
            n_grn = {r_colour[7:4], 12'h000};
            n_blu = {r_colour[3:0], 12'h000};
        end else begin
            n_red = gamma5(r_colour[15:11]);
            n_grn = gamma6(r_colour[10:5]);
            n_blu = gamma5(r_colour[4:0]);
        end
    end

    assign cur_last_col = (r_cur_col == r_win_right);
    assign cur_last_row = (r_cur_row == r_win_bottom);

    always_comb begin
        o_stat             = '0;
        o_stat.cmd         = r_cmd;
        o_stat.rect_empty  = (r_left > r_right) || (r_top > r_bottom);
        o_stat.exhausted   = r_exhausted;
        o_stat.transparent = (r_cmd == CMD_PIX565T) && (r_colour == 16'h0000);
        o_stat.on_panel    = ({1'b0, r_px_col} < 9'(PANEL_WIDTH)) &&
                             ({1'b0, r_px_row} < 8'(PANEL_HEIGHT));
        o_stat.plane_done  = !r_plane_act && !r_wr_pend;
        o_stat.clr_done    = &r_clr_cnt;
        o_stat.px_last_col = (r_px_col == r_right);
        o_stat.px_last_row = (r_px_row == r_bottom);
        o_stat.out_blocked = r_out_valid && !i_ready;
    end

    // Store port selection: clearing sweep or plane write-back.
    always_comb begin
        if (i_ctl.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else begin
            ram_we    = r_wr_pend && (r_wr_addr[PIX_AW-1:STORE_AW] == '0);
            ram_waddr = r_wr_addr[STORE_AW-1:0];
            ram_wdata = r_upper ? {r_wr_rgb, ram_rdata[2:0]} : {ram_rdata[5:3], r_wr_rgb};
        end
        ram_raddr = r_plane_act ? n_plane_addr[STORE_AW-1:0] : r_raddr_req;
    end

    lmbpw_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_right  <= '0;
            r_win_top    <= '0;
            r_win_bottom <= '0;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_exhausted  <= 1'b1;
            r_plane      <= '0;
            r_plane_act  <= 1'b0;
            r_wr_pend    <= 1'b0;
            r_res_skip   <= 1'b0;
            r_res_done   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.win_set) begin
                r_win_left   <= r_left;
                r_win_right  <= r_right;
                r_win_top    <= r_top;
                r_win_bottom <= r_bottom;
                r_cur_col    <= r_left;
                r_cur_row    <= r_top;
                r_exhausted  <= o_stat.rect_empty;
            end else if (i_ctl.cur_advance) begin
                if (cur_last_col) begin
                    if (cur_last_row) begin
                        r_exhausted <= 1'b1;
                    end else begin
                        r_cur_col <= r_win_left;
                        r_cur_row <= 7'(r_cur_row + 7'd1);
                    end
                end else begin
                    r_cur_col <= 8'(r_cur_col + 8'd1);
                end
            end

            if (i_ctl.plane_start) begin
                r_plane     <= '0;
                r_plane_act <= 1'b1;
            end else if (n_issue) begin
                r_plane <= PC_W'(r_plane + PC_W'(1));
            end else begin
                r_plane_act <= 1'b0;
            end
            r_wr_pend <= n_issue;

            if (i_ctl.latch) begin
                r_res_skip <= 1'b0;
                r_res_done <= 1'b0;
            end else begin
                if (i_ctl.set_skip) begin
                    r_res_skip <= 1'b1;
                end
                if (i_ctl.cur_advance && cur_last_col && cur_last_row) begin
                    r_res_done <= 1'b1;
                end
            end

            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd       <= t_cmd'(i_command);
            r_left      <= i_left_col;
            r_top       <= i_top_row;
            r_right     <= i_right_col;
            r_bottom    <= i_bottom_row;
            r_colour    <= i_colour;
            r_raddr_req <= i_read_address;
            r_res_data  <= '0;
        end else if (i_ctl.rd_capture) begin
            r_res_data <= ram_rdata;
        end

        if (i_ctl.fill_start) begin
            r_px_col <= r_left;
            r_px_row <= r_top;
        end else if (i_ctl.strm_start) begin
            r_px_col <= r_cur_col;
            r_px_row <= r_cur_row;
        end else if (i_ctl.px_next) begin
            if (o_stat.px_last_col) begin
                r_px_col <= r_left;
                r_px_row <= 7'(r_px_row + 7'd1);
            end else begin
                r_px_col <= 8'(r_px_col + 8'd1);
            end
        end

        if (i_ctl.fill_start || i_ctl.strm_start) begin
            r_red_src <= n_red;
            r_grn_src <= n_grn;
            r_blu_src <= n_blu;
        end

        if (i_ctl.pix_base) begin
            r_base  <= n_base;
            r_upper <= n_upper;
        end

        if (i_ctl.plane_start) begin
            r_red_sh <= r_red_src;
            r_grn_sh <= r_grn_src;
            r_blu_sh <= r_blu_src;
        end else if (n_issue) begin
            r_red_sh <= {r_red_sh[CHAN_W-2:0], 1'b0};
            r_grn_sh <= {r_grn_sh[CHAN_W-2:0], 1'b0};
            r_blu_sh <= {r_blu_sh[CHAN_W-2:0], 1'b0};
        end

        if (n_issue) begin
            r_wr_addr <= n_plane_addr;
            r_wr_rgb  <= {r_blu_sh[CHAN_W-1], r_grn_sh[CHAN_W-1], r_red_sh[CHAN_W-1]};
        end

        if (i_ctl.clr_start) begin
            r_clr_cnt <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr_cnt <= STORE_AW'(r_clr_cnt + STORE_AW'(1));
        end

        if (i_ctl.out_load) begin
            r_out_data <= r_res_data;
            r_out_skip <= r_res_skip;
            r_out_done <= r_res_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_skipped     = r_out_skip;
    assign o_window_done = r_out_done;

    a_plane_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plane <= PC_W'(PLANE_COUNT))
        else $error("Plane counter ran past the plane count.");

    a_cursor_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_exhausted |-> (r_cur_col <= r_win_right) && (r_cur_row >= r_win_top) &&
                         (r_cur_row <= r_win_bottom))
        else $error("Cursor left the open window.");

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> (!r_out_valid || i_ready))
        else $error("Result loaded over a request that was not taken.");

    a_last_pos_exhausts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.cur_advance && cur_last_col && cur_last_row) |=> (r_exhausted && r_res_done))
        else $error("Window not closed after its last position.");

endmodule

// ===== hdl/led_matrix_bitplane_pixel_writer.sv =====
// Top level of the bit-plane pixel writer for a two-half scanned LED matrix.
// One request at a time; the result appears on a registered output channel.
// A streamed pixel on the panel takes one store read and one write per bit plane; a fill
// does the same for each covered pixel on the panel. Clear writes zero to every store byte.
// Reset clears the control state and closes the window; store contents are undefined
// until the first clear request, and there is no clearing pass after reset.
module led_matrix_bitplane_pixel_writer
    import lmbpw_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int HALF_ROWS    = HALF_ROWS_DEF,
    parameter int PLANE_COUNT  = PLANE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_left_col,
    input  logic [6:0]  i_top_row,
    input  logic [7:0]  i_right_col,
    input  logic [6:0]  i_bottom_row,
    input  logic [15:0] i_colour,
    input  logic [15:0] i_read_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_read_data,
    output logic        o_skipped,
    output logic        o_window_done
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    lmbpw_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_stat (stat),
        .o_ctl  (ctl)
    );

    lmbpw_dp #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_HEIGHT(PANEL_HEIGHT),
        .HALF_ROWS   (HALF_ROWS),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_left_col    (i_left_col),
        .i_top_row     (i_top_row),
        .i_right_col   (i_right_col),
        .i_bottom_row  (i_bottom_row),
        .i_colour      (i_colour),
        .i_read_address(i_read_address),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_read_data   (o_read_data),
        .o_skipped     (o_skipped),
        .o_window_done (o_window_done)
    );

endmodule
